@@ hdl/npcs_pkg.sv @@
// Shared constants, codes and run/cycle types for the NAND page command sequencer.
package npcs_pkg;

  localparam int PAGE_BYTES      = 2048;
  localparam int PAGES_PER_BLOCK = 64;
  localparam int ROW_ADDR_BYTES  = 3;
  localparam int COL_ADDR_BYTES  = 2;

  localparam int COL_W       = $clog2(PAGE_BYTES);
  localparam int ROW_W       = 24;
  localparam int BURST_W     = 12;
  localparam int BLOCK_BYTES = PAGE_BYTES * PAGES_PER_BLOCK;
  localparam int BLOCK_LOG2  = $clog2(BLOCK_BYTES);

  // step layout of one run
  localparam int PG_ROW0 = 2 + COL_ADDR_BYTES;
  localparam int PG_TAIL = PG_ROW0 + ROW_ADDR_BYTES;
  localparam int PG_LEN  = PG_TAIL + 4;
  localparam int ER_TAIL = 2 + ROW_ADDR_BYTES;
  localparam int ER_LEN  = ER_TAIL + 3;
  localparam int ID_LEN  = 5;
  localparam int STEP_W  = $clog2(PG_LEN);
  localparam int ID_BURST = 5;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // request modes
  localparam logic [2:0] MODE_READ  = 3'd0;
  localparam logic [2:0] MODE_PROG  = 3'd1;
  localparam logic [2:0] MODE_ERASE = 3'd2;
  localparam logic [2:0] MODE_ID    = 3'd3;
  localparam logic [2:0] MODE_CONT  = 3'd4;

  // active operation
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_PROG  = 2'd1;
  localparam logic [1:0] OP_ERASE = 2'd2;
  localparam logic [1:0] OP_ID    = 2'd3;

  // bus cycle kinds
  localparam logic [2:0] K_SELECT   = 3'd0;
  localparam logic [2:0] K_CMD      = 3'd1;
  localparam logic [2:0] K_ADDR     = 3'd2;
  localparam logic [2:0] K_WAIT     = 3'd3;
  localparam logic [2:0] K_RBURST   = 3'd4;
  localparam logic [2:0] K_WBURST   = 3'd5;
  localparam logic [2:0] K_DESELECT = 3'd6;
  localparam logic [2:0] K_ERROR    = 3'd7;

  // NAND command bytes
  localparam logic [7:0] CMD_READ1  = 8'h00;
  localparam logic [7:0] CMD_READ2  = 8'h30;
  localparam logic [7:0] CMD_PROG1  = 8'h80;
  localparam logic [7:0] CMD_PROG2  = 8'h10;
  localparam logic [7:0] CMD_ERASE1 = 8'h60;
  localparam logic [7:0] CMD_ERASE2 = 8'hD0;
  localparam logic [7:0] CMD_ID     = 8'h90;
  localparam logic [7:0] ID_ADDR    = 8'h00;

  // error codes
  localparam logic [7:0] ERR_ADDR_ALIGN = 8'd1;
  localparam logic [7:0] ERR_LEN_ALIGN  = 8'd2;
  localparam logic [7:0] ERR_LEN_ZERO   = 8'd3;
  localparam logic [7:0] ERR_IDLE_CONT  = 8'd4;
  localparam logic [7:0] ERR_BAD_MODE   = 8'd5;

  typedef enum logic [2:0] {
    RUN_ERROR      = 3'd0,
    RUN_READ_EMPTY = 3'd1,
    RUN_READ       = 3'd2,
    RUN_PROG       = 3'd3,
    RUN_ERASE      = 3'd4,
    RUN_ID         = 3'd5
  } run_kind_t;

  // one classified run, handed from front to back
  typedef struct packed {
    run_kind_t            kind;
    logic [7:0]           code;
    logic [COL_W-1:0]     column;
    logic [ROW_W-1:0]     row;
    logic [BURST_W-1:0]   chunk;
    logic                 done;
  } run_t;

  // one bus cycle result
  typedef struct packed {
    logic [2:0]         kind;
    logic [7:0]         value;
    logic [BURST_W-1:0] burst;
    logic               done;
    logic               last;
  } cyc_t;

endpackage

@@ hdl/nand_page_command_sequencer.sv @@
// Top level of the NAND page command sequencer: front, run queue, back, output register.
//
// Usage:
//   Request side is a queue write port: a request (mode, byte_address, length) is taken at a
//   clock edge with push high and full low. Modes: read, program, block erase, read ID start
//   an operation; continue moves an open read/program/erase on by one page or one block.
//   Result side is a queue read port: while empty is low, the oldest bus cycle (cycle_kind,
//   byte_value, burst_bytes, op_done, last) is on the ports; pop high at an edge takes it.
//   Each request yields a run of 1 to 11 bus cycles; last marks the final cycle of a run.
// Path: with the run queue and output register free, a taken request is classified by the
//   front into the run queue, and the back end then loads the first cycle of its run into
//   the output register, from which it is on the ports.
// Throughput: one bus cycle per clock while pop is held and a run waits in the queue. The back
//   end's step counter sets that rate, one step per bus cycle; the front end
//   takes a request per clock until the two-entry run queue fills.
// Reset (rst, synchronous): clears the operation state (active operation read, not busy,
//   page/column/remaining zero), empties the run queue and the output register.
// Stall: with pop low the output register holds its cycle, the back end stops stepping,
//   the run queue fills and full rises; no request or cycle is lost.
module nand_page_command_sequencer import npcs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  mode,
  input  logic [31:0] byte_address,
  input  logic [31:0] length,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  cycle_kind,
  output logic [7:0]  byte_value,
  output logic [11:0] burst_bytes,
  output logic        op_done,
  output logic        last
);

  logic accept;
  run_t front_run;
  run_t head_run;
  logic head_valid;
  logic run_pop;
  cyc_t back_cyc;

  logic out_valid;
  cyc_t out_cyc;
  logic out_load;

  assign accept = push && !full;

  npcs_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .mode         (mode),
    .byte_address (byte_address),
    .length       (length),
    .run          (front_run)
  );

  npcs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (accept),
    .wr_run     (front_run),
    .rd_en      (run_pop),
    .head       (head_run),
    .head_valid (head_valid),
    .full       (full)
  );

  // output register takes a new cycle when empty or being popped
  assign out_load = !out_valid || pop;

  npcs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .run       (head_run),
    .run_valid (head_valid),
    .take      (out_load),
    .cyc       (back_cyc),
    .run_pop   (run_pop)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && head_valid) begin
      out_cyc <= back_cyc;
    end
  end

  assign empty       = !out_valid;
  assign cycle_kind  = out_cyc.kind;
  assign byte_value  = out_cyc.value;
  assign burst_bytes = out_cyc.burst;
  assign op_done     = out_cyc.done;
  assign last        = out_cyc.last;

`ifndef SYNTHESIS
  // error cycles stand alone and never finish an operation
  a_error_alone: assert property (@(posedge clk) disable iff (rst)
    (!empty && cycle_kind == K_ERROR) |-> (last && !op_done))
    else $error("error cycle not a lone run");

  // only burst cycles carry a byte count
  a_burst_only: assert property (@(posedge clk) disable iff (rst)
    (!empty && cycle_kind != K_RBURST && cycle_kind != K_WBURST) |-> (burst_bytes == '0))
    else $error("byte count on a non-burst cycle");

  // a run opens with select or error
  a_run_start: assert property (@(posedge clk) disable iff (rst)
    (!empty && $past(!empty && pop && last && !rst)) |->
      (cycle_kind == K_SELECT || cycle_kind == K_ERROR))
    else $error("run does not open with select");
`endif

endmodule

@@ hdl/npcs_front.sv @@
// Front end: classifies requests, keeps operation state, builds run descriptors.
module npcs_front import npcs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [2:0]  mode,
  input  logic [31:0] byte_address,
  input  logic [31:0] length,
  output run_t        run
);

  logic [1:0]       active_op, active_op_next;
  logic             busy, busy_next;
  logic [ROW_W-1:0] row_page, row_page_next;
  logic [COL_W-1:0] column, column_next;
  logic [31:0]      remaining, remaining_next;

  logic [ROW_W-1:0] addr_row, src_row;
  logic [COL_W-1:0] addr_col, src_col;
  logic [31:0]      src_rem, room, chunk, page_rem, blk_rem;
  logic             do_page, do_block, page_prog;

  assign addr_row = ROW_W'(byte_address >> COL_W);
  assign addr_col = byte_address[COL_W-1:0];

  always_comb begin
    if (mode == MODE_CONT) begin
      src_row = row_page;
      src_col = column;
      src_rem = remaining;
    end else begin
      src_row = addr_row;
      src_col = addr_col;
      src_rem = length;
    end
    room     = 32'(PAGE_BYTES) - 32'(src_col);
    chunk    = (src_rem < room) ? src_rem : room;
    page_rem = src_rem - chunk;
    blk_rem  = (src_rem >= 32'(BLOCK_BYTES)) ? src_rem - 32'(BLOCK_BYTES) : 32'd0;
  end

  always_comb begin
    active_op_next = active_op;
    busy_next      = busy;
    row_page_next  = row_page;
    column_next    = column;
    remaining_next = remaining;
    do_page        = 1'b0;
    do_block       = 1'b0;
    page_prog      = (mode == MODE_CONT) ? (active_op == OP_PROG) : (mode == MODE_PROG);
    run            = '0;
    run.kind       = RUN_ERROR;

    unique case (mode) inside
      MODE_READ, MODE_PROG: begin
        active_op_next = mode[1:0];
        if (mode == MODE_READ && length == 32'd0) begin
          row_page_next  = addr_row;
          column_next    = addr_col;
          remaining_next = 32'd0;
          busy_next      = 1'b0;
          run.kind       = RUN_READ_EMPTY;
          run.done       = 1'b1;
        end else begin
          do_page = 1'b1;
        end
      end
      MODE_ERASE: begin
        if (byte_address[BLOCK_LOG2-1:0] != '0) begin
          run.code = ERR_ADDR_ALIGN;
        end else if (length[BLOCK_LOG2-1:0] != '0) begin
          run.code = ERR_LEN_ALIGN;
        end else if (length == 32'd0) begin
          run.code = ERR_LEN_ZERO;
        end else begin
          active_op_next = OP_ERASE;
          do_block       = 1'b1;
        end
      end
      MODE_ID: begin
        active_op_next = OP_ID;
        busy_next      = 1'b0;
        run.kind       = RUN_ID;
        run.done       = 1'b1;
      end
      MODE_CONT: begin
        if (!busy) begin
          run.code = ERR_IDLE_CONT;
        end else if (active_op == OP_ERASE) begin
          do_block = 1'b1;
        end else begin
          do_page = 1'b1;
        end
      end
      default: begin
        run.code = ERR_BAD_MODE;
      end
    endcase

    if (do_page) begin
      run.kind       = page_prog ? RUN_PROG : RUN_READ;
      run.column     = src_col;
      run.row        = src_row;
      run.chunk      = BURST_W'(chunk);
      run.done       = (page_rem == 32'd0);
      column_next    = '0;
      row_page_next  = src_row + ROW_W'(1);
      remaining_next = page_rem;
      busy_next      = (page_rem != 32'd0);
    end
    if (do_block) begin
      run.kind       = RUN_ERASE;
      run.row        = src_row;
      run.done       = (blk_rem == 32'd0);
      column_next    = '0;
      row_page_next  = src_row + ROW_W'(PAGES_PER_BLOCK);
      remaining_next = blk_rem;
      busy_next      = (blk_rem != 32'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_op <= OP_READ;
      busy      <= 1'b0;
      row_page  <= '0;
      column    <= '0;
      remaining <= '0;
    end else if (accept) begin
      active_op <= active_op_next;
      busy      <= busy_next;
      row_page  <= row_page_next;
      column    <= column_next;
      remaining <= remaining_next;
    end
  end

endmodule

@@ hdl/npcs_queue.sv @@
// Short run queue between front and back.
module npcs_queue import npcs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  run_t wr_run,
  input  logic rd_en,
  output run_t head,
  output logic head_valid,
  output logic full
);

  run_t               entries [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [Q_CNT_W-1:0] count;

  assign head       = entries[rd_ptr];
  assign head_valid = (count != '0);
  assign full       = (count == Q_CNT_W'(Q_DEPTH));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_run;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + Q_PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + Q_PTR_W'(1);
      end
      count <= count + Q_CNT_W'(wr_en) - Q_CNT_W'(rd_en);
    end
  end

endmodule

@@ hdl/npcs_back.sv @@
// Back end: steps through one run and produces one bus cycle per step.
module npcs_back import npcs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  run_t run,
  input  logic run_valid,
  input  logic take,
  output cyc_t cyc,
  output logic run_pop
);

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] col_idx, row_idx;
  logic [7:0]        col_byte, row_byte;
  logic              advance;

  assign col_idx  = step - STEP_W'(2);
  assign row_idx  = (run.kind == RUN_ERASE) ? step - STEP_W'(2) : step - STEP_W'(PG_ROW0);
  assign col_byte = 8'({{(32-COL_W){1'b0}}, run.column} >> {col_idx, 3'b000});
  assign row_byte = 8'({{(32-ROW_W){1'b0}}, run.row} >> {row_idx, 3'b000});

  always_comb begin
    cyc       = '0;
    cyc.done  = run.done;
    cyc.kind  = K_DESELECT;
    unique case (run.kind) inside
      RUN_READ, RUN_PROG: begin
        cyc.last = (step == STEP_W'(PG_LEN - 1));
        if (step == '0) begin
          cyc.kind = K_SELECT;
        end else if (step == STEP_W'(1)) begin
          cyc.kind  = K_CMD;
          cyc.value = (run.kind == RUN_PROG) ? CMD_PROG1 : CMD_READ1;
        end else if (step < STEP_W'(PG_ROW0)) begin
          cyc.kind  = K_ADDR;
          cyc.value = col_byte;
        end else if (step < STEP_W'(PG_TAIL)) begin
          cyc.kind  = K_ADDR;
          cyc.value = row_byte;
        end else if (step == STEP_W'(PG_TAIL)) begin
          if (run.kind == RUN_PROG) begin
            cyc.kind  = K_WBURST;
            cyc.burst = run.chunk;
          end else begin
            cyc.kind  = K_CMD;
            cyc.value = CMD_READ2;
          end
        end else if (step == STEP_W'(PG_TAIL + 1)) begin
          if (run.kind == RUN_PROG) begin
            cyc.kind  = K_CMD;
            cyc.value = CMD_PROG2;
          end else begin
            cyc.kind = K_WAIT;
          end
        end else if (step == STEP_W'(PG_TAIL + 2)) begin
          if (run.kind == RUN_PROG) begin
            cyc.kind = K_WAIT;
          end else begin
            cyc.kind  = K_RBURST;
            cyc.burst = run.chunk;
          end
        end
      end
      RUN_ERASE: begin
        cyc.last = (step == STEP_W'(ER_LEN - 1));
        if (step == '0) begin
          cyc.kind = K_SELECT;
        end else if (step == STEP_W'(1)) begin
          cyc.kind  = K_CMD;
          cyc.value = CMD_ERASE1;
        end else if (step < STEP_W'(ER_TAIL)) begin
          cyc.kind  = K_ADDR;
          cyc.value = row_byte;
        end else if (step == STEP_W'(ER_TAIL)) begin
          cyc.kind  = K_CMD;
          cyc.value = CMD_ERASE2;
        end else if (step == STEP_W'(ER_TAIL + 1)) begin
          cyc.kind = K_WAIT;
        end
      end
      RUN_ID: begin
        cyc.last = (step == STEP_W'(ID_LEN - 1));
        if (step == '0) begin
          cyc.kind = K_SELECT;
        end else if (step == STEP_W'(1)) begin
          cyc.kind  = K_CMD;
          cyc.value = CMD_ID;
        end else if (step == STEP_W'(2)) begin
          cyc.kind  = K_ADDR;
          cyc.value = ID_ADDR;
        end else if (step == STEP_W'(3)) begin
          cyc.kind  = K_RBURST;
          cyc.burst = BURST_W'(ID_BURST);
        end
      end
      RUN_READ_EMPTY: begin
        cyc.last = (step == STEP_W'(1));
        if (step == '0) begin
          cyc.kind = K_SELECT;
        end
      end
      default: begin
        cyc.kind  = K_ERROR;
        cyc.value = run.code;
        cyc.done  = 1'b0;
        cyc.last  = 1'b1;
      end
    endcase
  end

  assign advance = run_valid && take;
  assign run_pop = advance && cyc.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (advance) begin
      step <= cyc.last ? '0 : step + STEP_W'(1);
    end
  end

endmodule
